/* hdl/pbs32_pkg.sv */
// ----------------------------------------------------------------------------
// pbs32_pkg
// shared types and constants for the pcm byte to stereo s32 converter
// ----------------------------------------------------------------------------
`default_nettype none

package pbs32_pkg;

  // sample format codes, as written to the format register
  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S24 = 2'd2,
    FMT_S32 = 2'd3
  } sample_fmt_t;

  // register indexes on the configuration port
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_SAMPLE_FORMAT = 1'b1;

  localparam int FrameBits   = 64;
  localparam int GatherBits  = 56;
  localparam int SampleBits  = 32;
  localparam int QueueDepth  = 2;
  localparam int QueuePtrW   = $clog2(QueueDepth);
  localparam int QueueCountW = $clog2(QueueDepth + 1);

  // one complete input frame with the format it was gathered under
  typedef struct packed {
    logic [FrameBits-1:0] frame;
    sample_fmt_t          fmt;
    logic                 mono;
  } frame_t;

endpackage

`default_nettype wire

/* hdl/pcm_bytes_to_stereo_s32.sv */
// ----------------------------------------------------------------------------
// pcm_bytes_to_stereo_s32
// little-endian pcm byte stream (u8, s16, s24, s32; mono or stereo) to
// stereo frames of two left-aligned signed 32-bit samples
// ----------------------------------------------------------------------------
// the input takes one byte per cycle, except for the stall named below
// a frame's last byte goes into the queue; the result register loads it from there
// the front stalls on a frame's last byte only while the two-entry queue is full
// reset (rst_n low, synchronous): stereo, s32, empty frame, empty queue, no output
// any register write restarts the frame being gathered
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_bytes_to_stereo_s32 (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // byte input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_data_byte,
  // stereo result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_left_sample,
  output logic signed [31:0]      out_right_sample,
  // apb configuration port, register i at byte address 4*i
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import pbs32_pkg::*;

  logic [1:0]  channel_count_r;
  sample_fmt_t sample_format_r;
  logic        reg_index;
  logic        cfg_write;
  logic        mono;

  frame_t      push_data;
  frame_t      pop_data;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  // only a channel count of one selects mono; zero and three act as stereo
  assign mono = channel_count_r == 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= 2'd2;
      sample_format_r <= FMT_S32;
    end else if (cfg_write) begin
      case (reg_index)
        REG_CHANNEL_COUNT: channel_count_r <= pwdata[1:0];
        REG_SAMPLE_FORMAT: sample_format_r <= sample_fmt_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CHANNEL_COUNT: prdata = {30'd0, channel_count_r};
      REG_SAMPLE_FORMAT: prdata = {30'd0, sample_format_r};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // front: byte gathering, stalled on a frame's last byte while the queue is full, else one transfer per cycle
  // ---------------------------------------------------------------------------
  pbs32_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .clear        (cfg_write),
    .fmt          (sample_format_r),
    .mono         (mono),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_data  (push_data)
  );

  // ---------------------------------------------------------------------------
  // queue: complete frames, each tagged with its format and channel mode
  // ---------------------------------------------------------------------------
  pbs32_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // ---------------------------------------------------------------------------
  // back: sample alignment and the registered result
  // ---------------------------------------------------------------------------
  pbs32_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_data           (pop_data),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample)
  );

endmodule

`default_nettype wire

/* hdl/pbs32_front.sv */
// ----------------------------------------------------------------------------
// pbs32_front
// gathers input bytes into frames and pushes complete frames to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module pbs32_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                clear,
  input  wire pbs32_pkg::sample_fmt_t fmt,
  input  wire logic                mono,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                q_full,
  output logic                     q_push,
  output pbs32_pkg::frame_t        q_push_data
);
  import pbs32_pkg::*;

  logic [2:0]            pos_r;
  logic [2:0]            pos_nxt;
  logic [GatherBits-1:0] gathered_r;
  logic [GatherBits-1:0] gathered_nxt;
  logic [3:0]            sample_len;
  logic [3:0]            frame_len;
  logic                  last_byte;
  logic [FrameBits-1:0]  frame_w;
  logic                  accept;

  assign sample_len = {2'b00, fmt} + 4'd1;
  assign frame_len  = mono ? sample_len : {sample_len[2:0], 1'b0};
  assign last_byte  = ({1'b0, pos_r} + 4'd1) >= frame_len;

  assign frame_w = {{(FrameBits-GatherBits){1'b0}}, gathered_r}
                 | ({{(FrameBits-8){1'b0}}, in_data_byte} << {pos_r, 3'b000});

  // a byte that does not end a frame never needs queue room
  assign in_ready = !q_full || !last_byte;
  assign accept   = in_valid && in_ready;

  assign q_push      = accept && last_byte;
  assign q_push_data = '{frame: frame_w, fmt: fmt, mono: mono};

  always_comb begin
    pos_nxt      = pos_r;
    gathered_nxt = gathered_r;
    if (accept) begin
      if (last_byte) begin
        pos_nxt      = 3'd0;
        gathered_nxt = '0;
      end else begin
        pos_nxt      = pos_r + 3'd1;
        gathered_nxt = frame_w[GatherBits-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      pos_r      <= 3'd0;
      gathered_r <= '0;
    end else begin
      pos_r      <= pos_nxt;
      gathered_r <= gathered_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/pbs32_queue.sv */
// ----------------------------------------------------------------------------
// pbs32_queue
// short frame queue between the gather front and the conversion back
// ----------------------------------------------------------------------------
`default_nettype none

module pbs32_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pbs32_pkg::frame_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output pbs32_pkg::frame_t      pop_data,
  output logic                   empty
);
  import pbs32_pkg::*;

  frame_t                 mem_r [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_r;
  logic [QueuePtrW-1:0]   rd_ptr_r;
  logic [QueueCountW-1:0] count_r;
  logic [QueueCountW-1:0] count_nxt;
  logic                   do_push;
  logic                   do_pop;

  assign full     = count_r == QueueCountW'(QueueDepth);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/pbs32_back.sv */
// ----------------------------------------------------------------------------
// pbs32_back
// turns a queued frame into two left-aligned samples in the output register
// ----------------------------------------------------------------------------
`default_nettype none

module pbs32_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pbs32_pkg::frame_t q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [31:0]     out_left_sample,
  output logic signed [31:0]     out_right_sample
);
  import pbs32_pkg::*;

  logic                  valid_r;
  logic [SampleBits-1:0] left_r;
  logic [SampleBits-1:0] right_r;
  logic [SampleBits-1:0] left_w;
  logic [SampleBits-1:0] right_w;

  always_comb begin
    case (q_data.fmt)
      FMT_U8: begin
        left_w  = {~q_data.frame[7], q_data.frame[6:0], 24'd0};
        right_w = {~q_data.frame[15], q_data.frame[14:8], 24'd0};
      end
      FMT_S16: begin
        left_w  = {q_data.frame[15:0], 16'd0};
        right_w = {q_data.frame[31:16], 16'd0};
      end
      FMT_S24: begin
        left_w  = {q_data.frame[23:0], 8'd0};
        right_w = {q_data.frame[47:24], 8'd0};
      end
      FMT_S32: begin
        left_w  = q_data.frame[31:0];
        right_w = q_data.frame[63:32];
      end
      default: begin
        left_w  = q_data.frame[31:0];
        right_w = q_data.frame[63:32];
      end
    endcase
    if (q_data.mono) begin
      right_w = left_w;
    end
  end

  assign q_pop            = !q_empty && (!valid_r || out_ready);
  assign out_valid        = valid_r;
  assign out_left_sample  = left_r;
  assign out_right_sample = right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      left_r  <= left_w;
      right_r <= right_w;
    end
  end

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for pcm_bytes_to_stereo_s32
// feeds pcm byte streams under every channel count and sample format, writes
// and reads back the registers over apb, and checks each stereo frame against
// an in-bench predictor of the byte gathering and left alignment
// ----------------------------------------------------------------------------

module testbench;
  import pbs32_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomBytes = 1620;
  // margin after the last due frame for the pipe to empty
  localparam int DrainCycles = 8;

  localparam logic [2:0] ChanAddr = {REG_CHANNEL_COUNT, 2'b00};
  localparam logic [2:0] FmtAddr  = {REG_SAMPLE_FORMAT, 2'b00};

  typedef struct {
    logic signed [31:0] left;
    logic signed [31:0] right;
  } stereo_frame_t;

  // dut signals, the inputs all driven to known values from time zero
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_left_sample;
  logic signed [31:0] out_right_sample;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = 3'd0;
  logic [31:0]        pwdata = 32'd0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor copy of the register settings and the frame being gathered
  logic [1:0]         cfg_channels;
  sample_fmt_t        cfg_format;
  int                 frame_fill;
  logic [55:0]        frame_store;
  stereo_frame_t      pending_frames[$];

  // run bookkeeping
  bit                 steady = 1'b0;  // no idling on either side while set
  int                 errors = 0;
  int                 bytes_taken = 0;
  int                 frames_seen = 0;
  int                 cfg_phases = 0;
  int                 cycle_count = 0;

  pcm_bytes_to_stereo_s32 uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_left_sample  (out_left_sample),
    .out_right_sample (out_right_sample),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one left-aligned sample from n little-endian bytes starting at byte offset
  function automatic logic signed [31:0] align_sample(input logic [63:0] frame,
                                                      input int offset, input int n);
    logic [31:0] v;
    int i;
    v = '0;
    for (i = 0; i < n; i++) begin
      v[8*(4-n+i) +: 8] = frame[8*((offset+i) % 8) +: 8];
    end
    // unsigned 8-bit: flip the sign bit to center on zero
    if (n == 1) begin
      v[31] = ~v[31];
    end
    return v;
  endfunction

  // take one byte into the frame; a finished frame becomes an expected result
  function automatic void absorb_byte(input logic [7:0] b);
    int n, flen;
    bit mono;
    logic [63:0] frame;
    stereo_frame_t r;
    n = int'(cfg_format) + 1;
    // only the code 1 means mono, 0 and 3 are taken as stereo
    mono = (cfg_channels == 2'd1);
    flen = mono ? n : 2 * n;
    frame = {8'h00, frame_store} | (64'(b) << (8 * (frame_fill % 8)));
    if ((frame_fill % 8) + 1 < flen) begin
      frame_store = frame[55:0];
      frame_fill  = (frame_fill % 8) + 1;
    end else begin
      r.left  = align_sample(frame, 0, n);
      r.right = mono ? r.left : align_sample(frame, n, n);
      pending_frames.push_back(r);
      frame_fill  = 0;
      frame_store = '0;
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // monitor: checks results first, then predicts from the byte taken on the same
  // edge (a byte can never complete a result on the edge it is taken)
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    stereo_frame_t want;
    cycle_count++;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_frames.size() == 0) begin
          flag_mismatch($sformatf("frame with none due: L=%h R=%h",
                                  out_left_sample, out_right_sample));
        end else begin
          want = pending_frames.pop_front();
          if (out_left_sample !== want.left) begin
            flag_mismatch($sformatf("left_sample %h, want %h", out_left_sample, want.left));
          end
          if (out_right_sample !== want.right) begin
            flag_mismatch($sformatf("right_sample %h, want %h", out_right_sample, want.right));
          end
          frames_seen++;
        end
      end
      if (in_valid && in_ready) begin
        absorb_byte(in_data_byte);
        bytes_taken++;
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("run stopped at cycle limit with %0d frames due", pending_frames.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // output back-pressure: stall about 19 percent of the time unless steady
  always @(negedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 19);
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // byte values biased toward the sign and range edges
  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one byte transfer, called and returning at a falling edge
  task automatic push_byte(input logic [7:0] b);
    if (!steady && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // count bytes of a little-endian word, byte 0 first
  task automatic push_frame(input logic [63:0] bytes, input int count);
    int i;
    for (i = 0; i < count; i++) begin
      push_byte(bytes[8*i +: 8]);
    end
  endtask

  // stop sending, wait for every due frame, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
  endtask

  // apb write: setup, access, then an idle phase before the next transfer
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // register written on this edge; any write restarts the frame
    if (addr == ChanAddr) begin
      cfg_channels = data[1:0];
    end else begin
      cfg_format = sample_fmt_t'(data[1:0]);
    end
    frame_fill  = 0;
    frame_store = '0;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // apb read with check against the predictor copy
  task automatic apb_check_read(input logic [2:0] addr);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = (addr == ChanAddr) ? {30'd0, cfg_channels} : {30'd0, cfg_format};
    if (prdata !== want) begin
      flag_mismatch($sformatf("register read at %0d gave %h, want %h", addr, prdata, want));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // new settings once idle; upper data bits are don't-care noise
  task automatic set_format(input logic [1:0] ch, input sample_fmt_t fmt);
    settle();
    apb_write(ChanAddr, {30'($urandom()), ch});
    apb_write(FmtAddr, {30'($urandom()), fmt});
    apb_check_read(ChanAddr);
    apb_check_read(FmtAddr);
    cfg_phases++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset gives stereo s32: full-scale negative left, full-scale positive right
  task automatic test_reset_state();
    apb_check_read(ChanAddr);
    apb_check_read(FmtAddr);
    push_frame(64'h7FFF_FFFF_8000_0000, 8);
  endtask

  // u8 mono, s16 and s24 stereo at their extremes
  task automatic test_narrow_formats();
    set_format(2'd1, FMT_U8);
    push_frame(64'h0000_0000_0000_FF00, 2);
    set_format(2'd2, FMT_S16);
    push_frame(64'h0000_0000_7FFF_8000, 4);
    set_format(2'd2, FMT_S24);
    push_frame(64'h0000_7FFF_FF80_0000, 6);
  endtask

  // channel codes 0 and 3 behave as stereo
  task automatic test_channel_codes();
    set_format(2'd0, FMT_U8);
    push_frame(64'h0000_0000_0000_7F80, 2);
    set_format(2'd3, FMT_U8);
    push_frame(64'h0000_0000_0000_FE01, 2);
  endtask

  // a register write in the middle of a frame drops the bytes gathered so far
  task automatic test_write_restarts_frame();
    set_format(2'd2, FMT_U8);
    push_byte(8'h55);
    settle();
    apb_write(FmtAddr, {30'd0, FMT_U8});
    push_frame(64'h0000_0000_0000_11AA, 2);
  endtask

  // random phases: mono and stereo in each format, then random ones; mostly whole
  // frames with a cut-off frame now and then; a few phases run with no idling at all
  task automatic test_random_streams();
    int phase, sent, frames, flen, nb, i;
    logic [1:0] ch;
    sample_fmt_t fmt;
    phase = 0;
    sent  = 0;
    while (sent < RandomBytes) begin
      if (phase < 8) begin
        ch  = (phase < 4) ? 2'd1 : 2'd2;
        fmt = sample_fmt_t'(phase % 4);
      end else begin
        ch  = 2'($urandom_range(0, 3));
        fmt = sample_fmt_t'($urandom_range(0, 3));
      end
      steady = (phase >= 9 && phase < 12);
      set_format(ch, fmt);
      flen   = (int'(fmt) + 1) * ((ch == 2'd1) ? 1 : 2);
      frames = $urandom_range(4, 40);
      for (i = 0; i < frames * flen; i++) begin
        push_byte(noisy_byte());
      end
      sent += frames * flen;
      // leave a partial frame for the next register write to discard
      if (flen > 1 && $urandom_range(0, 3) == 0) begin
        nb = $urandom_range(1, flen - 1);
        for (i = 0; i < nb; i++) begin
          push_byte(noisy_byte());
        end
        sent += nb;
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_channels = 2'd2;
    cfg_format   = FMT_S32;
    frame_fill   = 0;
    frame_store  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_narrow_formats();
    test_channel_codes();
    test_write_restarts_frame();
    test_random_streams();

    settle();
    $display("%0d byte transfers gave %0d stereo frames over %0d register settings",
             bytes_taken, frames_seen, cfg_phases);
    $display("formats u8/s16/s24/s32, channel codes 0-3, partial frames cut by writes");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
